/* hw/rtl/assert_macros.svh */
// assertion macros shared by the lane sweep sequencer rtl
// each macro samples on clk and is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property that must hold on every edge
`define LSFS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define LSFS_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LSFS_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/lsfs_pkg.sv */
// types and constants for the lane sweep flight sequencer
// used by lsfs_ctrl, lsfs_datapath and the top level; depends on nothing
package lsfs_pkg;

    localparam int DW         = 28;   // signed horizontal delta, 1/512 m
    localparam int SQW        = 56;   // squared distance
    localparam int RW         = 28;   // square root and divisor
    localparam int NW         = 40;   // dividend
    localparam int VW         = 12;   // velocity word
    localparam int EW         = 18;   // altitude error
    localparam int SQRT_STEPS = SQW / 2;
    localparam int DIV_STEPS  = NW;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    localparam int ASC_CEILING = 2560;
    localparam int ASC_DIVE    = -512;
    localparam int ASC_GAIN    = 205;
    localparam int ASC_LIMIT   = 256;
    localparam int HALF_LIMIT  = 128;
    localparam int MIN_DIST    = 1024;
    localparam int VEL_MAX     = 2047;

    localparam logic [2:0] REG_SWEEP_ALT   = 3'd0;
    localparam logic [2:0] REG_SPEED       = 3'd1;
    localparam logic [2:0] REG_WIDTH       = 3'd2;
    localparam logic [2:0] REG_LENGTH      = 3'd3;
    localparam logic [2:0] REG_GAP         = 3'd4;
    localparam logic [2:0] REG_TOL         = 3'd5;
    localparam logic [2:0] REG_LINGER      = 3'd6;
    localparam logic [2:0] REG_LINGER_ALT  = 3'd7;

    typedef enum logic [2:0] {
        MODE_ASCEND = 3'd0,
        MODE_SWEEP  = 3'd1,
        MODE_INVEST = 3'd2,
        MODE_RETURN = 3'd3,
        MODE_DONE   = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        VS_ZERO,
        VS_ASC,
        VS_HALF,
        VS_FULL
    } vsel_t;

    typedef struct packed {
        logic               position_fresh;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic               target_seen;
    } tick_word_t;

    typedef struct packed {
        logic signed [11:0] vel_x;
        logic signed [11:0] vel_y;
        logic signed [11:0] vel_z;
        logic [2:0]         flight_mode;
        logic [6:0]         lane_number;
        logic [15:0]        linger_elapsed;
    } cmd_word_t;

    typedef struct packed {
        logic [14:0] sweep_altitude;
        logic [10:0] cruise_speed;
        logic [13:0] area_width;
        logic [13:0] area_length;
        logic [13:0] lane_gap;
        logic [10:0] arrive_tolerance;
        logic [15:0] linger_ticks;
        logic [14:0] linger_altitude;
    } cfg_t;

    typedef struct packed {
        logic        load;
        logic        prep;
        logic        sqx;
        logic        sqy;
        logic        sqrt_init;
        logic        sqrt_step;
        logic        mul;
        logic        div_init;
        logic        div_step;
        logic        emit;
        mode_t       mode;
        vsel_t       vsel;
        logic [15:0] elapsed;
    } lsfs_cmd_t;

    typedef struct packed {
        logic seen;
        logic lanes_done;
        logic near;
        logic asc_near;
        logic root_zero;
        logic out_free;
    } lsfs_status_t;

endpackage

/* hw/rtl/lane_sweep_flight_sequencer_unit.sv */
// lane sweep flight sequencer top level: configuration registers and the
// controller / datapath pair; uses lsfs_pkg, lsfs_ctrl and lsfs_datapath
//
// tick channel (tick_valid / tick_stall / tick_word) carries one control tick:
// an optional fresh position and a target flag. cmd channel (cmd_valid /
// cmd_stall / cmd_word) returns velocity commands, mode, lane and linger count.
// cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the eight
// setup registers; cfg_ready is always high; write only while idle.
// one tick is taken at a time. a tick before any position gives no word. in
// ascend, investigate, done, when the lanes are done, or on a waypoint or home
// hit the word is registered after the prep, squaring and decide steps, and
// the next tick is taken once that word is emitted. a tick that steers toward
// a waypoint or home also runs 28 square root steps plus 40 divider steps
// before its word, with both horizontal axes divided in parallel.
// the output word register lets a new tick be taken while a word waits; a
// held cmd_stall only holds the next finished word back.
// reset puts the mission in ascend at lane 0 with no position known and loads
// the register defaults.
module lane_sweep_flight_sequencer_unit
    import lsfs_pkg::*;
#(
    parameter int MAX_LANES = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tick_valid,
    output logic        tick_stall,
    input  tick_word_t  tick_word,
    output logic        cmd_valid,
    input  logic        cmd_stall,
    output cmd_word_t   cmd_word,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int LW = $clog2(MAX_LANES + 1);

    cfg_t         cfg_reg;
    lsfs_cmd_t    cmd;
    lsfs_status_t status;
    logic [LW-1:0] lane;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sweep_altitude   <= 15'd768;
            cfg_reg.cruise_speed     <= 11'd256;
            cfg_reg.area_width       <= 14'd2560;
            cfg_reg.area_length      <= 14'd3840;
            cfg_reg.lane_gap         <= 14'd512;
            cfg_reg.arrive_tolerance <= 11'd77;
            cfg_reg.linger_ticks     <= 16'd200;
            cfg_reg.linger_altitude  <= 15'd512;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SWEEP_ALT:  cfg_reg.sweep_altitude   <= cfg_data[14:0];
                REG_SPEED:      cfg_reg.cruise_speed     <= cfg_data[10:0];
                REG_WIDTH:      cfg_reg.area_width       <= cfg_data[13:0];
                REG_LENGTH:     cfg_reg.area_length      <= cfg_data[13:0];
                REG_GAP:        cfg_reg.lane_gap         <= cfg_data[13:0];
                REG_TOL:        cfg_reg.arrive_tolerance <= cfg_data[10:0];
                REG_LINGER:     cfg_reg.linger_ticks     <= cfg_data;
                REG_LINGER_ALT: cfg_reg.linger_altitude  <= cfg_data[14:0];
            endcase
        end
    end

    lsfs_ctrl #(
        .MAX_LANES(MAX_LANES)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick_valid    (tick_valid),
        .tick_stall    (tick_stall),
        .position_fresh(tick_word.position_fresh),
        .target_seen   (tick_word.target_seen),
        .linger_ticks  (cfg_reg.linger_ticks),
        .status        (status),
        .cmd           (cmd),
        .lane          (lane)
    );

    lsfs_datapath #(
        .MAX_LANES(MAX_LANES)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick_word(tick_word),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .lane     (lane),
        .cmd_stall(cmd_stall),
        .cmd_valid(cmd_valid),
        .cmd_word (cmd_word),
        .status   (status)
    );

endmodule

/* hw/rtl/lsfs_datapath.sv */
// datapath: position latch, deltas, squared distance, shift-add square root,
// two restoring dividers and the output word register; uses lsfs_pkg
module lsfs_datapath
    import lsfs_pkg::*;
#(
    parameter int MAX_LANES = 64,
    localparam int LW = $clog2(MAX_LANES + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  tick_word_t    tick_word,
    input  cfg_t          cfg,
    input  lsfs_cmd_t     cmd,
    input  logic [LW-1:0] lane,
    input  logic          cmd_stall,
    output logic          cmd_valid,
    output cmd_word_t     cmd_word,
    output lsfs_status_t  status
);

    localparam int GPW = LW + 14;

    logic signed [15:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic               seen_reg;
    logic signed [DW-1:0] dx_reg, dy_reg;
    logic [23:0]        thr_reg;
    logic               lanes_done_reg;
    logic signed [VW-1:0] asc_vz_reg, half_vz_reg;
    logic               asc_near_reg;
    logic [SQW-1:0]     d2_reg, rem_reg, root_reg, bit_reg;
    logic [RW-1:0]      d_reg;
    logic [NW-1:0]      prodx_reg, prody_reg, numx_reg, numy_reg, qx_reg, qy_reg;
    logic [RW-1:0]      remx_reg, remy_reg;
    logic               out_valid_reg;
    cmd_word_t          out_word_reg;

    // prep stage
    logic [GPW-1:0]       gp;
    logic                 lanes_done;
    logic signed [DW-1:0] xs, ys, len_s, wid_s, gp2, tx2, ty2, dx, dy;
    logic [21:0]          tol2;
    logic signed [EW-1:0] e, a, tgt;
    logic [EW-1:0]        abs_e, abs_a, half_mag;
    logic [EW+7:0]        pmag, amag;
    logic                 above;
    logic signed [VW-1:0] asc_vz, half_vz;
    logic [DW-1:0]        magx, magy;
    logic [SQW-1:0]       sum;
    logic [RW:0]          tx, ty;

    function automatic logic signed [VW-1:0] sat_vel(input logic neg, input logic [NW-1:0] q);
        logic signed [VW-1:0] r;
        if (neg)
        begin
            if (q >= NW'(VEL_MAX + 1))
                r = -VW'(VEL_MAX) - VW'(1);
            else
                r = -signed'(VW'(q));
        end
        else
        begin
            if (q >= NW'(VEL_MAX))
                r = VW'(VEL_MAX);
            else
                r = signed'(VW'(q));
        end
        return r;
    endfunction

    always_comb
    begin
        gp         = GPW'(lane) * GPW'(cfg.lane_gap);
        lanes_done = (lane >= LW'(MAX_LANES))
                     || ((cfg.lane_gap != '0) && (gp > GPW'(cfg.area_width)));
        xs    = DW'(pos_x_reg);
        ys    = DW'(pos_y_reg);
        len_s = signed'(DW'(cfg.area_length));
        wid_s = signed'(DW'(cfg.area_width));
        gp2   = signed'(DW'({gp, 1'b0}));
        tx2   = lane[0] ? -len_s : len_s;
        ty2   = gp2 - wid_s;
        tol2  = 22'(cfg.arrive_tolerance) * 22'(cfg.arrive_tolerance);
        if (cmd.mode == MODE_SWEEP)
        begin
            dx = tx2 - (xs <<< 1);
            dy = ty2 - (ys <<< 1);
        end
        else
        begin
            dx = -xs;
            dy = -ys;
        end

        // ascend: proportional climb with a dive above the ceiling
        e     = signed'(EW'(cfg.sweep_altitude)) - EW'(pos_z_reg);
        abs_e = e[EW-1] ? EW'(-e) : EW'(e);
        pmag  = ((EW + 8)'(abs_e) * (EW + 8)'(ASC_GAIN) + (EW + 8)'(128)) >> 8;
        above = abs_e > EW'(cfg.arrive_tolerance);
        if (pos_z_reg > 16'sd2560)
            asc_vz = VW'(ASC_DIVE);
        else if (above)
        begin
            if (pmag > (EW + 8)'(ASC_LIMIT))
                asc_vz = e[EW-1] ? -VW'(ASC_LIMIT) : VW'(ASC_LIMIT);
            else
                asc_vz = e[EW-1] ? -signed'(VW'(pmag)) : signed'(VW'(pmag));
        end
        else
            asc_vz = '0;

        // vertical hold toward a target altitude at half gain
        unique case (cmd.mode)
            MODE_SWEEP:  tgt = signed'(EW'(cfg.sweep_altitude));
            MODE_INVEST: tgt = signed'(EW'(cfg.linger_altitude));
            default:     tgt = '0;
        endcase
        a        = tgt - EW'(pos_z_reg);
        abs_a    = a[EW-1] ? EW'(-a) : EW'(a);
        amag     = (EW + 8)'(abs_a) + (EW + 8)'(1);
        half_mag = EW'(amag >> 1);
        if (half_mag > EW'(HALF_LIMIT))
            half_vz = a[EW-1] ? -VW'(HALF_LIMIT) : VW'(HALF_LIMIT);
        else
            half_vz = a[EW-1] ? -signed'(VW'(half_mag)) : signed'(VW'(half_mag));

        magx = dx_reg[DW-1] ? DW'(-dx_reg) : DW'(dx_reg);
        magy = dy_reg[DW-1] ? DW'(-dy_reg) : DW'(dy_reg);
        sum  = root_reg + bit_reg;
        tx   = {remx_reg, numx_reg[NW-1]};
        ty   = {remy_reg, numy_reg[NW-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load && tick_word.position_fresh)
                seen_reg <= 1'b1;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!cmd_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && tick_word.position_fresh)
        begin
            pos_x_reg <= tick_word.pos_x;
            pos_y_reg <= tick_word.pos_y;
            pos_z_reg <= tick_word.pos_z;
        end
        if (cmd.prep)
        begin
            dx_reg         <= dx;
            dy_reg         <= dy;
            thr_reg        <= (cmd.mode == MODE_SWEEP) ? {tol2, 2'b00} : 24'(tol2);
            lanes_done_reg <= lanes_done;
            asc_vz_reg     <= asc_vz;
            half_vz_reg    <= half_vz;
            asc_near_reg   <= abs_e < EW'(cfg.arrive_tolerance);
        end
        if (cmd.sqx)
            d2_reg <= SQW'(magx) * SQW'(magx);
        if (cmd.sqy)
            d2_reg <= d2_reg + SQW'(magy) * SQW'(magy);
        if (cmd.sqrt_init)
        begin
            rem_reg  <= d2_reg;
            root_reg <= '0;
            bit_reg  <= SQW'(1) << (SQW - 2);
        end
        if (cmd.sqrt_step)
        begin
            if (rem_reg >= sum)
            begin
                rem_reg  <= rem_reg - sum;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
                root_reg <= root_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.mul)
        begin
            if ((cmd.mode == MODE_SWEEP) && (root_reg < SQW'(MIN_DIST)))
                d_reg <= RW'(MIN_DIST);
            else
                d_reg <= root_reg[RW-1:0];
            prodx_reg <= NW'(magx) * NW'(cfg.cruise_speed);
            prody_reg <= NW'(magy) * NW'(cfg.cruise_speed);
        end
        if (cmd.div_init)
        begin
            numx_reg <= prodx_reg + NW'(d_reg >> 1);
            numy_reg <= prody_reg + NW'(d_reg >> 1);
            remx_reg <= '0;
            remy_reg <= '0;
            qx_reg   <= '0;
            qy_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            numx_reg <= numx_reg << 1;
            numy_reg <= numy_reg << 1;
            if (tx >= {1'b0, d_reg})
            begin
                remx_reg <= RW'(tx - {1'b0, d_reg});
                qx_reg   <= {qx_reg[NW-2:0], 1'b1};
            end
            else
            begin
                remx_reg <= tx[RW-1:0];
                qx_reg   <= {qx_reg[NW-2:0], 1'b0};
            end
            if (ty >= {1'b0, d_reg})
            begin
                remy_reg <= RW'(ty - {1'b0, d_reg});
                qy_reg   <= {qy_reg[NW-2:0], 1'b1};
            end
            else
            begin
                remy_reg <= ty[RW-1:0];
                qy_reg   <= {qy_reg[NW-2:0], 1'b0};
            end
        end
        if (cmd.emit)
        begin
            unique case (cmd.vsel)
                VS_ZERO:
                begin
                    out_word_reg.vel_x <= '0;
                    out_word_reg.vel_y <= '0;
                    out_word_reg.vel_z <= '0;
                end
                VS_ASC:
                begin
                    out_word_reg.vel_x <= '0;
                    out_word_reg.vel_y <= '0;
                    out_word_reg.vel_z <= asc_vz_reg;
                end
                VS_HALF:
                begin
                    out_word_reg.vel_x <= '0;
                    out_word_reg.vel_y <= '0;
                    out_word_reg.vel_z <= half_vz_reg;
                end
                VS_FULL:
                begin
                    out_word_reg.vel_x <= sat_vel(dx_reg[DW-1], qx_reg);
                    out_word_reg.vel_y <= sat_vel(dy_reg[DW-1], qy_reg);
                    out_word_reg.vel_z <= half_vz_reg;
                end
            endcase
            out_word_reg.flight_mode    <= cmd.mode;
            out_word_reg.lane_number    <= 7'(lane);
            out_word_reg.linger_elapsed <= cmd.elapsed;
        end
    end

    assign status.seen       = seen_reg;
    assign status.lanes_done = lanes_done_reg;
    assign status.near       = d2_reg < SQW'(thr_reg);
    assign status.asc_near   = asc_near_reg;
    assign status.root_zero  = (root_reg == '0);
    assign status.out_free   = !out_valid_reg || !cmd_stall;

    assign cmd_valid = out_valid_reg;
    assign cmd_word  = out_word_reg;

endmodule

/* hw/rtl/lsfs_ctrl.sv */
// mission controller: mode, lane index and linger count, plus the step
// sequencer that drives lsfs_datapath; uses lsfs_pkg and assert_macros.svh
`include "assert_macros.svh"

module lsfs_ctrl
    import lsfs_pkg::*;
#(
    parameter int MAX_LANES = 64,
    localparam int LW = $clog2(MAX_LANES + 1)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          tick_valid,
    output logic          tick_stall,
    input  logic          position_fresh,
    input  logic          target_seen,
    input  logic [15:0]   linger_ticks,
    input  lsfs_status_t  status,
    output lsfs_cmd_t     cmd,
    output logic [LW-1:0] lane
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_SQX,
        S_SQY,
        S_DECIDE,
        S_SQRT,
        S_MUL,
        S_DINIT,
        S_DIV,
        S_EMIT
    } state_t;

    state_t           state_reg;
    mode_t            mode_reg;
    logic [LW-1:0]    lane_reg;
    logic [15:0]      linger_reg;
    logic [15:0]      elapsed_reg;
    vsel_t            vsel_reg;
    logic [CNT_W-1:0] cnt_reg;

    always_comb
    begin
        cmd         = '0;
        cmd.mode    = mode_reg;
        cmd.vsel    = vsel_reg;
        cmd.elapsed = elapsed_reg;
        unique case (state_reg)
            S_IDLE:   cmd.load      = tick_valid;
            S_PREP:   cmd.prep      = 1'b1;
            S_SQX:    cmd.sqx       = 1'b1;
            S_SQY:    cmd.sqy       = 1'b1;
            S_DECIDE: cmd.sqrt_init = 1'b1;
            S_SQRT:   cmd.sqrt_step = 1'b1;
            S_MUL:    cmd.mul       = 1'b1;
            S_DINIT:  cmd.div_init  = 1'b1;
            S_DIV:    cmd.div_step  = 1'b1;
            S_EMIT:   cmd.emit      = status.out_free;
        endcase
    end

    assign tick_stall = (state_reg != S_IDLE);
    assign lane       = lane_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            mode_reg    <= MODE_ASCEND;
            lane_reg    <= '0;
            linger_reg  <= '0;
            elapsed_reg <= '0;
            vsel_reg    <= VS_ZERO;
            cnt_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (tick_valid)
                    begin
                        if (target_seen && (mode_reg == MODE_SWEEP))
                        begin
                            mode_reg   <= MODE_INVEST;
                            linger_reg <= '0;
                        end
                        // no word until a position has ever arrived
                        if (status.seen || position_fresh)
                            state_reg <= S_PREP;
                    end
                end
                S_PREP: state_reg <= S_SQX;
                S_SQX:  state_reg <= S_SQY;
                S_SQY:  state_reg <= S_DECIDE;
                S_DECIDE:
                begin
                    elapsed_reg <= linger_reg;
                    cnt_reg     <= '0;
                    state_reg   <= S_EMIT;
                    unique case (mode_reg)
                        MODE_ASCEND:
                        begin
                            vsel_reg <= VS_ASC;
                            if (status.asc_near)
                                mode_reg <= MODE_SWEEP;
                        end
                        MODE_SWEEP:
                        begin
                            vsel_reg <= VS_ZERO;
                            if (status.lanes_done)
                                mode_reg <= MODE_RETURN;
                            else if (status.near)
                                lane_reg <= lane_reg + LW'(1);
                            else
                            begin
                                vsel_reg  <= VS_FULL;
                                state_reg <= S_SQRT;
                            end
                        end
                        MODE_INVEST:
                        begin
                            vsel_reg <= VS_HALF;
                            if (linger_reg >= linger_ticks)
                                mode_reg <= MODE_SWEEP;
                            else if (linger_reg != 16'hFFFF)
                                linger_reg <= linger_reg + 16'd1;
                        end
                        MODE_RETURN:
                        begin
                            vsel_reg <= VS_ZERO;
                            if (status.near)
                                mode_reg <= MODE_DONE;
                            else
                            begin
                                vsel_reg  <= VS_FULL;
                                state_reg <= S_SQRT;
                            end
                        end
                        default:
                        begin
                            vsel_reg <= VS_ZERO;
                            mode_reg <= MODE_DONE;
                        end
                    endcase
                end
                S_SQRT:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    // zero distance leaves only the vertical term
                    if (status.root_zero)
                        vsel_reg <= VS_HALF;
                    state_reg <= S_DINIT;
                end
                S_DINIT: state_reg <= S_DIV;
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (status.out_free)
                        state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `LSFS_ASSERT(a_lane_range, lane_reg <= LW'(MAX_LANES), "lane index past the lane cap")
    `LSFS_ASSERT_NXT(a_done_sticks, mode_reg == MODE_DONE, mode_reg == MODE_DONE, "left done mode")
    `LSFS_ASSERT_NXT(a_tick_starts, (state_reg == S_IDLE) && tick_valid && (status.seen || position_fresh), state_reg == S_PREP, "tick with a known position did not start work")

endmodule

/* test/tb_lane_sweep_flight_sequencer_unit.sv */
// self-checking testbench for lane_sweep_flight_sequencer_unit
// predicts every command word from its own mission model; depends on lsfs_pkg
`timescale 1ns / 100ps

module tb_lane_sweep_flight_sequencer_unit;
    import lsfs_pkg::*;

    localparam int LANE_CAP   = 64;
    localparam int CYCLE_CAP  = 2000000;
    localparam int NUM_REGS   = 8;

    class flight_scoreboard;
        mode_t     mode;
        int        lane;
        int        linger;
        bit        seen;
        int        px, py, pz;
        int        cfg [NUM_REGS];
        cmd_word_t pending [$];
        int        errors;

        function void init();
            cfg[REG_SWEEP_ALT]  = 768;
            cfg[REG_SPEED]      = 256;
            cfg[REG_WIDTH]      = 2560;
            cfg[REG_LENGTH]     = 3840;
            cfg[REG_GAP]        = 512;
            cfg[REG_TOL]        = 77;
            cfg[REG_LINGER]     = 200;
            cfg[REG_LINGER_ALT] = 512;
            mode = MODE_ASCEND;
            lane = 0;
            linger = 0;
            seen = 0;
            px = 0;
            py = 0;
            pz = 0;
            errors = 0;
        endfunction

        function longint round_div(longint n, longint d);
            longint m;
            m = n < 0 ? -n : n;
            m = (m + d / 2) / d;
            return n < 0 ? -m : m;
        endfunction

        function longint clip(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function longint root(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return longint'(r);
        endfunction

        // advance the mission by one tick and queue the word it yields
        function void note_tick(tick_word_t w);
            longint vx, vy, vz, e, tol, spd, dx, dy, d, d2, lanes, elapsed;
            cmd_word_t c;
            vx = 0;
            vy = 0;
            vz = 0;
            if (w.position_fresh)
            begin
                px = w.pos_x;
                py = w.pos_y;
                pz = w.pos_z;
                seen = 1;
            end
            if (w.target_seen && mode == MODE_SWEEP)
            begin
                mode = MODE_INVEST;
                linger = 0;
            end
            if (!seen)
                return;
            tol = cfg[REG_TOL];
            spd = cfg[REG_SPEED];
            elapsed = linger;
            case (mode)
                MODE_ASCEND:
                begin
                    e = cfg[REG_SWEEP_ALT] - pz;
                    if (pz > ASC_CEILING)
                        vz = ASC_DIVE;
                    else if ((e < 0 ? -e : e) > tol)
                        vz = clip(round_div(e * ASC_GAIN, 256), -ASC_LIMIT, ASC_LIMIT);
                    if ((e < 0 ? -e : e) < tol)
                        mode = MODE_SWEEP;
                end
                MODE_SWEEP:
                begin
                    lanes = cfg[REG_GAP] == 0 ? LANE_CAP : cfg[REG_WIDTH] / cfg[REG_GAP] + 1;
                    if (lanes > LANE_CAP)
                        lanes = LANE_CAP;
                    if (lane >= lanes)
                        mode = MODE_RETURN;
                    else
                    begin
                        // doubled units keep the half lengths exact
                        dx = ((lane & 1) ? -cfg[REG_LENGTH] : cfg[REG_LENGTH]) - 2 * px;
                        dy = -cfg[REG_WIDTH] + 2 * lane * cfg[REG_GAP] - 2 * py;
                        d2 = dx * dx + dy * dy;
                        if (d2 < 4 * tol * tol)
                            lane++;
                        else
                        begin
                            d = root(d2);
                            if (d < MIN_DIST)
                                d = MIN_DIST;
                            vx = round_div(dx * spd, d);
                            vy = round_div(dy * spd, d);
                            vz = clip(round_div(cfg[REG_SWEEP_ALT] - pz, 2),
                                      -HALF_LIMIT, HALF_LIMIT);
                        end
                    end
                end
                MODE_INVEST:
                begin
                    vz = clip(round_div(cfg[REG_LINGER_ALT] - pz, 2), -HALF_LIMIT, HALF_LIMIT);
                    if (linger >= cfg[REG_LINGER])
                        mode = MODE_SWEEP;
                    else if (linger < 65535)
                        linger++;
                end
                MODE_RETURN:
                begin
                    dx = -px;
                    dy = -py;
                    d2 = dx * dx + dy * dy;
                    if (d2 < tol * tol)
                        mode = MODE_DONE;
                    else
                    begin
                        d = root(d2);
                        if (d > 0)
                        begin
                            vx = round_div(dx * spd, d);
                            vy = round_div(dy * spd, d);
                        end
                        vz = clip(round_div(-pz, 2), -HALF_LIMIT, HALF_LIMIT);
                    end
                end
                default:
                    mode = MODE_DONE;
            endcase
            c.vel_x = clip(vx, -2048, VEL_MAX);
            c.vel_y = clip(vy, -2048, VEL_MAX);
            c.vel_z = clip(vz, -2048, VEL_MAX);
            c.flight_mode = mode;
            c.lane_number = lane;
            c.linger_elapsed = elapsed;
            pending.push_back(c);
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        task check_cmd(cmd_word_t got);
            cmd_word_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected word %h", got));
                return;
            end
            want = pending.pop_front();
            if (got.vel_x !== want.vel_x)
                report($sformatf("vel_x %0d, want %0d", got.vel_x, want.vel_x));
            if (got.vel_y !== want.vel_y)
                report($sformatf("vel_y %0d, want %0d", got.vel_y, want.vel_y));
            if (got.vel_z !== want.vel_z)
                report($sformatf("vel_z %0d, want %0d", got.vel_z, want.vel_z));
            if (got.flight_mode !== want.flight_mode)
                report($sformatf("flight_mode %0d, want %0d", got.flight_mode,
                                 want.flight_mode));
            if (got.lane_number !== want.lane_number)
                report($sformatf("lane_number %0d, want %0d", got.lane_number,
                                 want.lane_number));
            if (got.linger_elapsed !== want.linger_elapsed)
                report($sformatf("linger_elapsed %0d, want %0d", got.linger_elapsed,
                                 want.linger_elapsed));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        tick_valid;
    logic        tick_stall;
    tick_word_t  tick_word;
    logic        cmd_valid;
    logic        cmd_stall;
    cmd_word_t   cmd_word;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    flight_scoreboard mission;
    int send_idle_pct;
    int recv_stall_pct;
    int near_pct;
    int cycles;

    lane_sweep_flight_sequencer_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .tick_word  (tick_word),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd_word   (cmd_word),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
        clk = 0;
    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("tb_lane_sweep_flight_sequencer_unit NOT OK");
            $finish;
        end
    end

    // receiving side: random stall, check each word taken
    always @(posedge clk)
    begin
        if (rst_n && cmd_valid && !cmd_stall)
            mission.check_cmd(cmd_word);
        cmd_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function logic signed [15:0] sat16(longint v);
        return v < -32768 ? -32768 : (v > 32767 ? 32767 : v);
    endfunction

    // aims near the current goal some of the time so the mission moves on
    function tick_word_t make_tick();
        tick_word_t w;
        longint jit, ox, oy, oz, gx, gy, gz;
        w.position_fresh = ($urandom_range(7) != 0);
        w.target_seen = ($urandom_range(19) == 0);
        w.pos_x = $urandom;
        w.pos_y = $urandom;
        w.pos_z = $urandom;
        if ($urandom_range(99) < near_pct)
        begin
            jit = mission.cfg[REG_TOL] / 4;
            ox = longint'($urandom_range(2 * jit)) - jit;
            oy = longint'($urandom_range(2 * jit)) - jit;
            oz = longint'($urandom_range(2 * jit)) - jit;
            gx = w.pos_x;
            gy = w.pos_y;
            gz = mission.cfg[REG_SWEEP_ALT];
            case (mission.mode)
                MODE_SWEEP:
                begin
                    gx = ((mission.lane & 1) ? -mission.cfg[REG_LENGTH]
                                             : mission.cfg[REG_LENGTH]) / 2;
                    gy = (-mission.cfg[REG_WIDTH] + 2 * mission.lane * mission.cfg[REG_GAP]) / 2;
                end
                MODE_INVEST:
                    gz = mission.cfg[REG_LINGER_ALT];
                MODE_RETURN, MODE_DONE:
                begin
                    gx = 0;
                    gy = 0;
                    gz = 0;
                end
                default:
                    ;
            endcase
            w.pos_x = sat16(gx + ox);
            w.pos_y = sat16(gy + oy);
            w.pos_z = sat16(gz + oz);
        end
        return w;
    endfunction

    task send_tick(tick_word_t w);
        if ($urandom_range(99) < send_idle_pct)
        begin
            tick_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        tick_valid <= 1'b1;
        tick_word <= w;
        @(posedge clk);
        while (tick_stall)
            @(posedge clk);
        mission.note_tick(w);
    endtask

    task write_reg(logic [2:0] idx, int value);
        int widths [NUM_REGS];
        widths = '{15, 11, 14, 14, 14, 11, 16, 15};
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        mission.cfg[idx] = value & ((1 << widths[idx]) - 1);
    endtask

    // all words home, then room for a tick still in the datapath
    task drain();
        tick_valid <= 1'b0;
        while (mission.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task setup(int alt, int spd, int wid, int len, int gap, int tol, int lng, int lalt);
        write_reg(REG_SWEEP_ALT, alt);
        write_reg(REG_SPEED, spd);
        write_reg(REG_WIDTH, wid);
        write_reg(REG_LENGTH, len);
        write_reg(REG_GAP, gap);
        write_reg(REG_TOL, tol);
        write_reg(REG_LINGER, lng);
        write_reg(REG_LINGER_ALT, lalt);
        cfg_valid <= 1'b0;
    endtask

    task run_words(int count);
        for (int i = 0; i < count; i++)
            send_tick(make_tick());
        drain();
    endtask

    function tick_word_t pos(bit fresh, int x, int y, int z, bit tgt);
        tick_word_t w;
        w.position_fresh = fresh;
        w.pos_x = x;
        w.pos_y = y;
        w.pos_z = z;
        w.target_seen = tgt;
        return w;
    endfunction

    initial
    begin
        mission = new();
        mission.init();
        cycles <= 0;
        rst_n <= 1'b0;
        tick_valid <= 1'b0;
        tick_word <= '0;
        cmd_stall <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_SWEEP_ALT;
        cfg_data <= '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        near_pct = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no position yet, then altitude extremes, level off, first lane, detection
        send_tick(pos(0, 0, 0, 0, 1));
        send_tick(pos(0, 123, -5, 9, 0));
        send_tick(pos(1, 32767, -32768, 32767, 0));
        send_tick(pos(1, -32768, 32767, -32768, 1));
        send_tick(pos(1, 0, 0, 2560, 0));
        send_tick(pos(1, 5, 5, 691, 0));
        send_tick(pos(1, 5, 5, 700, 0));
        send_tick(pos(0, 0, 0, 0, 0));
        send_tick(pos(1, 1920, -1280, 768, 0));
        send_tick(pos(1, -32768, 32767, 0, 0));
        send_tick(pos(1, -1920, -768, 768, 1));
        send_tick(pos(0, 0, 0, 0, 0));
        send_tick(pos(1, 100, 100, 512, 1));
        drain();

        setup(32767, 2047, 16383, 16383, 1, 2047, 0, 32767);
        send_idle_pct = 17;
        recv_stall_pct = 50;
        near_pct = 8;
        run_words(550);

        setup(0, 0, 16383, 0, 256, 1, 65535, 0);
        send_idle_pct = 50;
        recv_stall_pct = 17;
        run_words(250);
        setup(1500, 1024, 16383, 9000, 256, 600, 3, 0);
        run_words(300);

        setup(768, 1000, 0, 3840, 0, 300, 5, 400);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        near_pct = 35;
        run_words(550);

        if (mission.pending.size() != 0)
            mission.report($sformatf("%0d words never arrived", mission.pending.size()));
        if (mission.errors == 0)
            $display("tb_lane_sweep_flight_sequencer_unit OK");
        else
            $display("tb_lane_sweep_flight_sequencer_unit NOT OK");
        $finish;
    end

endmodule
